// ----- rtl/pip_pkg.sv -----
`timescale 1ns / 1ps

package pip_pkg;

  // Capacity and coordinate format.
  localparam int MAX_VERTICES = 256;
  localparam int COORD_WIDTH  = 24;

  // Derived widths: store address, vertex count, differences and products.
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_TEST   = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_FEW   = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } pip_state_t;

  // Result of one edge evaluation, passed from the edge unit to the controller.
  typedef struct packed {
    logic valid;
    logic toggle;
    logic last;
  } pip_edge_res_t;

endpackage

// ----- rtl/pip_edge.sv -----
`timescale 1ns / 1ps

module pip_edge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  edge_valid,
  input  logic                                  edge_last,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] vi_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] vi_y,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] vj_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] vj_y,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] pt_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] pt_y,
  output pip_pkg::pip_edge_res_t                 res
);
  import pip_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic signed [DIFF_W-1:0]   a_nxt, b_nxt, dx_nxt, dy_nxt;
  logic                       straddle_nxt;
  logic signed [DIFF_W-1:0]   a_r, b_r, dx_r, dy_r;
  logic                       dy_pos_r, straddle_r, v1_r, l1_r;
  logic signed [PROD_W-1:0]   p1_r, p2_r;
  logic                       dy_pos2_r, straddle2_r, v2_r, l2_r;
  logic signed [PROD_W:0]     cmp_diff;
  logic                       left;
  pip_edge_res_t              res_r;

  // Stage one inputs: exact differences and the straddle test.
  always_comb begin
    a_nxt  = $signed({pt_x[CW-1], pt_x}) - $signed({vi_x[CW-1], vi_x});
    b_nxt  = $signed({pt_y[CW-1], pt_y}) - $signed({vi_y[CW-1], vi_y});
    dx_nxt = $signed({vj_x[CW-1], vj_x}) - $signed({vi_x[CW-1], vi_x});
    dy_nxt = $signed({vj_y[CW-1], vj_y}) - $signed({vi_y[CW-1], vi_y});
    straddle_nxt = (vi_y > pt_y) != (vj_y > pt_y);
  end

  // Stage one registers the differences.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= edge_valid;
    end
    l1_r       <= edge_last;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dy_pos_r   <= (dy_nxt > 0);
    straddle_r <= straddle_nxt;
  end

  // Stage two forms both cross products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    l2_r        <= l1_r;
    p1_r        <= a_r * dy_r;
    p2_r        <= dx_r * b_r;
    dy_pos2_r   <= dy_pos_r;
    straddle2_r <= straddle_r;
  end

  // Stage three compares the products; the sense follows the sign of dy.
  always_comb begin
    cmp_diff = $signed({p1_r[PROD_W-1], p1_r}) - $signed({p2_r[PROD_W-1], p2_r});
    left = dy_pos2_r ? cmp_diff[PROD_W] : (!cmp_diff[PROD_W] && (cmp_diff != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= v2_r;
    end
    res_r.toggle <= straddle2_r && left;
    res_r.last   <= l2_r;
  end

  assign res = res_r;

endmodule

// ----- rtl/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
// Clear and append requests give their result in the cycle after the transfer and never stall.
// A test over n stored vertices reads n + 1 store entries, one per cycle through the single
// read port, then passes the edge pipeline; busy stays high until the result is shown and
// falls in the same cycle as out_valid rises.
// A test with fewer than three vertices answers in the cycle after the transfer.
// Synchronous reset empties the polygon; the vertex store itself is not cleared.
// The receiver cannot stall: each result is shown for one cycle with out_valid high.

module point_in_polygon_test (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_req_type,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] in_coord_y,
  output logic                                  out_valid,
  output logic                                  out_inside_res,
  output logic [1:0]                            out_status
);
  import pip_pkg::*;

  localparam int CW = COORD_WIDTH;

  pip_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic signed [CW-1:0] tx_r, ty_r;
  logic                inside_r, inside_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_inside_r, out_inside_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                accept;
  logic                full;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    cnt_m1, step_m1;
  logic                rd_last;

  logic [2*CW-1:0]     mem [MAX_VERTICES];
  logic [2*CW-1:0]     rdata_r;
  logic                rvld_r, rfirst_r, rlast_r;
  logic [2*CW-1:0]     prev_r;

  pip_edge_res_t       edge_res;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign full    = (count_r == CNT_W'(MAX_VERTICES));
  assign wr_en   = accept && (in_req_type == REQ_APPEND) && !full;
  assign wr_addr = count_r[ADDR_W-1:0];

  // Read address: the last vertex first, then vertices zero upward.
  assign cnt_m1  = count_r - CNT_W'(1);
  assign step_m1 = step_r - CNT_W'(1);
  assign rd_en   = (state_r == ST_WALK);
  assign rd_addr = (step_r == '0) ? cnt_m1[ADDR_W-1:0] : step_m1[ADDR_W-1:0];
  assign rd_last = (step_r == count_r);

  // Vertex store: one write port for appends, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_coord_x, in_coord_y};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Read data tracking; the previous vertex closes each edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= rd_en;
    end
    rfirst_r <= (step_r == '0);
    rlast_r  <= rd_last;
    if (rvld_r) begin
      prev_r <= rdata_r;
    end
  end

  pip_edge u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .edge_valid (rvld_r && !rfirst_r),
    .edge_last  (rlast_r),
    .vi_x       (rdata_r[2*CW-1:CW]),
    .vi_y       (rdata_r[CW-1:0]),
    .vj_x       (prev_r[2*CW-1:CW]),
    .vj_y       (prev_r[CW-1:0]),
    .pt_x       (tx_r),
    .pt_y       (ty_r),
    .res        (edge_res)
  );

  // Request handling and the walk sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    inside_nxt     = inside_r;
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;
    out_status_nxt = out_status_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_inside_nxt = 1'b0;
          out_status_nxt = STAT_OK;
          case (in_req_type)
            REQ_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            REQ_APPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_TEST: begin
              if (count_r < CNT_W'(3)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_FEW;
              end else begin
                state_nxt  = ST_WALK;
                step_nxt   = '0;
                inside_nxt = 1'b0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        step_nxt = step_r + CNT_W'(1);
        if (rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (edge_res.valid) begin
          inside_nxt = inside_r ^ edge_res.toggle;
          if (edge_res.last) begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_inside_nxt = inside_r ^ edge_res.toggle;
            out_status_nxt = STAT_OK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Edges finished while the walk is still issuing reads toggle the flag too.
    if (state_r == ST_WALK && edge_res.valid) begin
      inside_nxt = inside_r ^ edge_res.toggle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    inside_r     <= inside_nxt;
    out_inside_r <= out_inside_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      tx_r <= in_coord_x;
      ty_r <= in_coord_y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_status     = out_status_r;

  // A result never appears while a test is still running.
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Edge results arrive only during a test.
  a_edge_only_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    edge_res.valid |-> (state_r != ST_IDLE))
    else $error("edge result outside a test");

  // The vertex count stays within capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above capacity");

  // A clear or append transfer is answered in the next cycle.
  a_quick_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type != REQ_TEST)) |=> out_valid)
    else $error("missing reply to clear or append");

  // No store write while the walk reads it.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("store write during walk");

endmodule

// ----- tb/point_in_polygon_test_tb.sv -----
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
  import pip_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One answer of the block: the inside flag and the status code.
  typedef struct packed {
    logic       in_poly;
    logic [1:0] status;
  } verdict_t;

  // The request code that the block answers but otherwise ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  // Coordinate spreads used when drawing vertices and query points.
  localparam int SPREAD_GRID = 0;
  localparam int SPREAD_MID  = 1;
  localparam int SPREAD_FULL = 2;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_req_type = REQ_CLEAR;
  coord_t     in_coord_x = '0;
  coord_t     in_coord_y = '0;
  logic       out_valid;
  logic       out_inside_res;
  logic [1:0] out_status;

  // Local copy of the polygon, kept in step with every accepted transfer.
  coord_t poly_x [MAX_VERTICES];
  coord_t poly_y [MAX_VERTICES];
  int     poly_count = 0;

  verdict_t pending_verdicts[$];

  logic quiet_sender = 1'b0;
  int   mismatches = 0;
  int   n_transfers = 0;
  int   n_inside = 0;
  int   n_outside = 0;
  int   n_few = 0;
  int   n_dropped = 0;
  int   n_unused = 0;

  point_in_polygon_test DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res),
    .out_status     (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Even-odd crossing count over every edge from vertex i back to vertex i-1.
  // Differences and products fit easily in 64 bits, so the comparison is exact.
  function automatic logic crossing_parity(coord_t qx, coord_t qy);
    logic   odd;
    logic   left;
    int     j;
    longint dx, dy, lhs, rhs;
    odd = 1'b0;
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      if ((poly_y[i] > qy) != (poly_y[j] > qy)) begin
        dx = longint'(poly_x[j]) - longint'(poly_x[i]);
        dy = longint'(poly_y[j]) - longint'(poly_y[i]);
        lhs = (longint'(qx) - longint'(poly_x[i])) * dy;
        rhs = dx * (longint'(qy) - longint'(poly_y[i]));
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // Applies one accepted request to the local polygon and returns its answer.
  function automatic verdict_t predict_verdict(logic [1:0] req, coord_t x, coord_t y);
    verdict_t v;
    v.in_poly = 1'b0;
    v.status = STAT_OK;
    case (req)
      REQ_CLEAR: poly_count = 0;
      REQ_APPEND: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end else begin
          v.status = STAT_FULL;
          n_dropped++;
        end
      end
      REQ_TEST: begin
        if (poly_count < 3) begin
          v.status = STAT_FEW;
          n_few++;
        end else begin
          v.in_poly = crossing_parity(x, y);
          if (v.in_poly) n_inside++;
          else n_outside++;
        end
      end
      default: n_unused++;
    endcase
    return v;
  endfunction

  function automatic coord_t rand_coord(int spread);
    coord_t c;
    case (spread)
      SPREAD_GRID: begin
        c = coord_t'($urandom_range(0, 16));
        c = c - coord_t'(8);
      end
      SPREAD_MID: begin
        c = coord_t'($urandom_range(0, 8192));
        c = c - coord_t'(4096);
      end
      default: begin
        case ($urandom_range(0, 7))
          0: c = COORD_MIN;
          1: c = COORD_MAX;
          default: c = coord_t'($urandom());
        endcase
      end
    endcase
    return c;
  endfunction

  // Sends one request after a random gap (none when the sender is quiet) and records its expected answer.
  // Start is left high after the transfer; the next call with a gap or wait_drained lowers it.
  task automatic send_request(input logic [1:0] req, input coord_t x, input coord_t y);
    int       gap;
    verdict_t v;
    gap = quiet_sender ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_coord_x <= x;
    in_coord_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = predict_verdict(req, x, y);
    pending_verdicts = {pending_verdicts, v};
    n_transfers++;
  endtask

  // Holds the sender off until every expected answer has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() > 0) @(posedge clk);
  endtask

  // Each answer is valid for one cycle and is compared with the oldest expectation.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected transfer, inside_res %0b status %0d", $time,
                 out_inside_res, out_status);
        mismatches++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_inside_res !== exp_v.in_poly) begin
          $display("%0t: inside_res mismatch, expected %0b actual %0b", $time,
                   exp_v.in_poly, out_inside_res);
          mismatches++;
        end
        if (out_status !== exp_v.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   exp_v.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Tests on an empty, one-vertex and two-vertex polygon must report too few vertices.
  task automatic test_few_vertices();
    send_request(REQ_TEST, 24'sd0, 24'sd0);
    send_request(REQ_APPEND, 24'sd5, -24'sd5);
    send_request(REQ_TEST, 24'sd5, -24'sd5);
    send_request(REQ_APPEND, -24'sd5, 24'sd5);
    send_request(REQ_TEST, 24'sd0, 24'sd0);
    send_request(REQ_CLEAR, COORD_MAX, COORD_MIN);
    send_request(REQ_TEST, 24'sd1, 24'sd1);
  endtask

  // The unused request code leaves the polygon alone and answers ok.
  task automatic test_unused_code();
    send_request(REQ_UNUSED, COORD_MAX, COORD_MAX);
    send_request(REQ_UNUSED, COORD_MIN, COORD_MIN);
  endtask

  // A square over the whole coordinate range, probed inside, at corners and on edges.
  task automatic test_extreme_square();
    send_request(REQ_CLEAR, 24'sd0, 24'sd0);
    send_request(REQ_APPEND, COORD_MIN, COORD_MIN);
    send_request(REQ_APPEND, COORD_MAX, COORD_MIN);
    send_request(REQ_APPEND, COORD_MAX, COORD_MAX);
    send_request(REQ_APPEND, COORD_MIN, COORD_MAX);
    send_request(REQ_TEST, 24'sd0, 24'sd0);
    send_request(REQ_TEST, -24'sd1, -24'sd1);
    send_request(REQ_TEST, COORD_MIN, COORD_MIN);
    send_request(REQ_TEST, COORD_MAX, COORD_MAX);
    send_request(REQ_TEST, COORD_MAX, 24'sd0);
    send_request(REQ_TEST, COORD_MIN, 24'sd0);
    send_request(REQ_TEST, 24'sd0, COORD_MIN);
    send_request(REQ_TEST, 24'sd0, COORD_MAX);
  endtask

  // Fills the store, overflows it, and runs the longest tests.
  task automatic test_capacity();
    send_request(REQ_CLEAR, 24'sd0, 24'sd0);
    repeat (MAX_VERTICES) send_request(REQ_APPEND, rand_coord(SPREAD_FULL),
                                       rand_coord(SPREAD_FULL));
    send_request(REQ_APPEND, COORD_MAX, COORD_MIN);
    send_request(REQ_APPEND, COORD_MIN, COORD_MAX);
    repeat (3) send_request(REQ_TEST, rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
    wait_drained();
    send_request(REQ_TEST, 24'sd0, 24'sd0);
    send_request(REQ_CLEAR, 24'sd0, 24'sd0);
    send_request(REQ_TEST, 24'sd0, 24'sd0);
  endtask

  // Mostly complete polygons with random shapes and probes, with some noise mixed in.
  task automatic test_random_polygons(input int budget);
    coord_t px[$], py[$];
    coord_t qx, qy;
    coord_t vx, vy;
    longint mx, my;
    int     stop_at, n, k, j, spread, roll;
    stop_at = n_transfers + budget;
    while (n_transfers < stop_at) begin
      roll = $urandom_range(0, 9);
      quiet_sender = ($urandom_range(0, 3) == 0);
      if (roll == 0) begin
        // Noise: an unused code, then a test on an incomplete polygon.
        send_request(REQ_UNUSED, rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
        send_request(REQ_CLEAR, rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
        repeat ($urandom_range(0, 2)) send_request(REQ_APPEND, rand_coord(SPREAD_FULL),
                                                   rand_coord(SPREAD_FULL));
        send_request(REQ_TEST, rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
      end else begin
        spread = $urandom_range(SPREAD_GRID, SPREAD_FULL);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        px.delete();
        py.delete();
        send_request(REQ_CLEAR, rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
        repeat (n) begin
          vx = rand_coord(spread);
          vy = rand_coord(spread);
          px = {px, vx};
          py = {py, vy};
          send_request(REQ_APPEND, vx, vy);
        end
        repeat ($urandom_range(2, 6)) begin
          k = $urandom_range(0, n - 1);
          j = (k == 0) ? n - 1 : k - 1;
          case ($urandom_range(0, 3))
            0: begin
              qx = px[k];
              qy = py[k];
            end
            1: begin
              // Midpoint of an edge, which often lands exactly on it.
              mx = (longint'(px[k]) + longint'(px[j])) >>> 1;
              my = (longint'(py[k]) + longint'(py[j])) >>> 1;
              qx = mx[COORD_WIDTH-1:0];
              qy = my[COORD_WIDTH-1:0];
            end
            default: begin
              qx = rand_coord(spread);
              qy = rand_coord(spread);
            end
          endcase
          send_request(REQ_TEST, qx, qy);
        end
        if (roll == 9) wait_drained();
      end
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_few_vertices();
    test_unused_code();
    test_extreme_square();
    wait_drained();
    test_capacity();
    test_random_polygons(160);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d transfers: %0d tests inside, %0d outside, %0d with too few vertices.",
             n_transfers, n_inside, n_outside, n_few);
    $display("Dropped appends on a full store: %0d; unused request codes: %0d.",
             n_dropped, n_unused);
    if (mismatches == 0) begin
      $display("point_in_polygon_test regression: pass");
    end else begin
      $display("point_in_polygon_test regression: fail");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d answers still expected.", pending_verdicts.size());
    $display("point_in_polygon_test regression: fail");
    $finish;
  end

endmodule
